FILE: rtl/swcd_pkg.sv
// Shared types, register map and codes for the three-mode millisecond timer.
`timescale 1ns / 1ps
`default_nettype none

package swcd_pkg;

   // Block configuration.
   localparam int COUNTDOWN_PRESETS = 3;
   localparam int WARN_SECONDS      = 3;

   localparam logic [31:0] MS_PER_S   = 32'd1000;
   localparam logic [31:0] MS_PER_MIN = 32'd60000;
   localparam logic [6:0]  NO_SECOND  = 7'd99;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 5;

   localparam logic [2:0] REG_CD_A    = 3'd0;
   localparam logic [2:0] REG_CD_B    = 3'd1;
   localparam logic [2:0] REG_CD_C    = 3'd2;
   localparam logic [2:0] REG_WORK_A  = 3'd3;
   localparam logic [2:0] REG_BREAK_A = 3'd4;
   localparam logic [2:0] REG_WORK_B  = 3'd5;
   localparam logic [2:0] REG_BREAK_B = 3'd6;

   // Command codes.
   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_SHORT = 3'd1;
   localparam logic [2:0] CMD_LONG  = 3'd2;
   localparam logic [2:0] CMD_MODE  = 3'd3;
   localparam logic [2:0] CMD_HALT  = 3'd4;

   // Sound event codes.
   localparam logic [2:0] SND_NONE   = 3'd0;
   localparam logic [2:0] SND_MODE   = 3'd1;
   localparam logic [2:0] SND_START  = 3'd2;
   localparam logic [2:0] SND_WARN   = 3'd3;
   localparam logic [2:0] SND_DONE   = 3'd4;
   localparam logic [2:0] SND_PRESET = 3'd5;
   localparam logic [2:0] SND_BREAK  = 3'd6;
   localparam logic [2:0] SND_WORK   = 3'd7;

   typedef enum logic [1:0] {
      MODE_STOPWATCH = 2'd0,
      MODE_COUNTDOWN = 2'd1,
      MODE_INTERVAL  = 2'd2
   } mode_type;

   typedef struct packed {
      logic [2:0][11:0] cd_s;
      logic [1:0][7:0]  work_min;
      logic [1:0][7:0]  break_min;
   } cfg_type;

   typedef struct packed {
      logic        stop;
      logic [2:0]  sound;
      logic [31:0] shown;
      logic [1:0]  preset;
      logic        in_break;
      logic        running;
      logic [1:0]  mode;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/swcd_csr.sv
// Configuration register file with an APB-style write and read port.
`timescale 1ns / 1ps
`default_nettype none

module swcd_csr
   import swcd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] index;
   logic       write_en;

   assign pready   = 1'b1;
   assign index    = paddr[CSR_ADDR_W-1:2];
   assign write_en = psel && penable && pwrite && pready;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_CD_A:    cfg_in.cd_s[0]      = pwdata[11:0];
            REG_CD_B:    cfg_in.cd_s[1]      = pwdata[11:0];
            REG_CD_C:    cfg_in.cd_s[2]      = pwdata[11:0];
            REG_WORK_A:  cfg_in.work_min[0]  = pwdata[7:0];
            REG_BREAK_A: cfg_in.break_min[0] = pwdata[7:0];
            REG_WORK_B:  cfg_in.work_min[1]  = pwdata[7:0];
            REG_BREAK_B: cfg_in.break_min[1] = pwdata[7:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_CD_A:    prdata = {20'd0, cfg_ff.cd_s[0]};
         REG_CD_B:    prdata = {20'd0, cfg_ff.cd_s[1]};
         REG_CD_C:    prdata = {20'd0, cfg_ff.cd_s[2]};
         REG_WORK_A:  prdata = {24'd0, cfg_ff.work_min[0]};
         REG_BREAK_A: prdata = {24'd0, cfg_ff.break_min[0]};
         REG_WORK_B:  prdata = {24'd0, cfg_ff.work_min[1]};
         REG_BREAK_B: prdata = {24'd0, cfg_ff.break_min[1]};
         default:     prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cd_s[0]      <= 12'd30;
         cfg_ff.cd_s[1]      <= 12'd60;
         cfg_ff.cd_s[2]      <= 12'd120;
         cfg_ff.work_min[0]  <= 8'd25;
         cfg_ff.break_min[0] <= 8'd5;
         cfg_ff.work_min[1]  <= 8'd50;
         cfg_ff.break_min[1] <= 8'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/swcd_core.sv
// Timer state and the single-pass command update that forms one status result.
`timescale 1ns / 1ps
`default_nettype none

module swcd_core
   import swcd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        item_fire,
   input  wire logic [2:0]  cmd,
   input  wire logic [31:0] now_ms,
   input  wire cfg_type     cfg,
   output result_type       result
);

   mode_type    mode_ff, mode_in, mode_next;
   logic        run_ff, run_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] cdl_ff, cdl_in;
   logic [6:0]  last_ff, last_in;
   logic [1:0]  cdc_ff, cdc_in, cdc_next;
   logic        ic_ff, ic_in;
   logic        brk_ff, brk_in;
   logic [31:0] il_ff, il_in;

   logic [31:0] elapsed;
   logic [31:0] cd_left_sub;
   logic [6:0]  warn_sec;
   logic        warn_hit;
   logic [2:0]  sound;
   logic        stop;
   logic [31:0] shown;
   logic [1:0]  preset;
   logic        in_break;

   function automatic logic [31:0] cd_full_ms(input logic [1:0] c, input cfg_type cf);
      logic [11:0] sec;
      if ({1'b0, c} >= 3'(COUNTDOWN_PRESETS) || c > 2'd2) begin
         sec = cf.cd_s[0];
      end else begin
         sec = cf.cd_s[c];
      end
      return 32'(sec) * MS_PER_S;
   endfunction

   function automatic logic [31:0] work_ms(input logic c, input cfg_type cf);
      return 32'(cf.work_min[c]) * MS_PER_MIN;
   endfunction

   function automatic logic [31:0] break_ms(input logic c, input cfg_type cf);
      return 32'(cf.break_min[c]) * MS_PER_MIN;
   endfunction

   assign elapsed     = now_ms - start_ff;
   assign cd_left_sub = cdl_ff - elapsed;

   // Whole seconds left, rounded up, when inside the warning window; zero otherwise.
   always_comb begin
      warn_sec = 7'd0;
      for (int k = WARN_SECONDS; k >= 1; k--) begin
         if (cd_left_sub <= 32'(k) * MS_PER_S) begin
            warn_sec = 7'(k);
         end
      end
   end

   assign warn_hit = (warn_sec != 7'd0) && (warn_sec != last_ff);

   always_comb begin
      cdc_next = 2'd0;
      if ({1'b0, cdc_ff} + 3'd1 < 3'(COUNTDOWN_PRESETS)) begin
         cdc_next = cdc_ff + 2'd1;
      end
   end

   always_comb begin
      case (mode_ff)
         MODE_STOPWATCH: mode_next = MODE_COUNTDOWN;
         MODE_COUNTDOWN: mode_next = MODE_INTERVAL;
         default:        mode_next = MODE_STOPWATCH;
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      run_in   = run_ff;
      acc_in   = acc_ff;
      start_in = start_ff;
      cdl_in   = cdl_ff;
      last_in  = last_ff;
      cdc_in   = cdc_ff;
      ic_in    = ic_ff;
      brk_in   = brk_ff;
      il_in    = il_ff;
      sound    = SND_NONE;
      stop     = 1'b0;
      case (cmd)
         CMD_TICK: begin
            if (run_ff && mode_ff == MODE_COUNTDOWN) begin
               start_in = now_ms;
               if (elapsed >= cdl_ff) begin
                  cdl_in = 32'd0;
                  run_in = 1'b0;
                  sound  = SND_DONE;
               end else begin
                  cdl_in = cd_left_sub;
                  if (warn_hit) begin
                     last_in = warn_sec;
                     sound   = SND_WARN;
                  end
               end
            end else if (run_ff && mode_ff == MODE_INTERVAL) begin
               start_in = now_ms;
               if (elapsed >= il_ff) begin
                  brk_in = !brk_ff;
                  il_in  = brk_ff ? work_ms(ic_ff, cfg) : break_ms(ic_ff, cfg);
                  sound  = brk_ff ? SND_WORK : SND_BREAK;
               end else begin
                  il_in = il_ff - elapsed;
               end
            end
         end
         CMD_SHORT: begin
            if (mode_ff == MODE_STOPWATCH && run_ff) begin
               acc_in = acc_ff + elapsed;
               run_in = 1'b0;
            end else if (run_ff) begin
               run_in = 1'b0;
            end else begin
               // Starting with nothing left re-arms the selected preset first.
               if (mode_ff == MODE_COUNTDOWN && cdl_ff == 32'd0) begin
                  cdl_in  = cd_full_ms(cdc_ff, cfg);
                  last_in = NO_SECOND;
               end else if (mode_ff == MODE_INTERVAL && il_ff == 32'd0) begin
                  brk_in = 1'b0;
                  il_in  = work_ms(ic_ff, cfg);
               end
               start_in = now_ms;
               run_in   = 1'b1;
            end
            sound = SND_START;
         end
         CMD_LONG: begin
            if (run_ff) begin
               run_in = 1'b0;
               stop   = 1'b1;
            end
            if (mode_ff == MODE_STOPWATCH) begin
               acc_in = 32'd0;
            end else if (mode_ff == MODE_COUNTDOWN) begin
               cdc_in  = cdc_next;
               cdl_in  = cd_full_ms(cdc_next, cfg);
               last_in = NO_SECOND;
               sound   = SND_PRESET;
            end else begin
               ic_in  = !ic_ff;
               brk_in = 1'b0;
               il_in  = work_ms(!ic_ff, cfg);
               sound  = SND_PRESET;
            end
         end
         CMD_MODE: begin
            run_in  = 1'b0;
            acc_in  = 32'd0;
            mode_in = mode_next;
            if (mode_next == MODE_COUNTDOWN) begin
               cdl_in  = cd_full_ms(cdc_ff, cfg);
               last_in = NO_SECOND;
            end else if (mode_next == MODE_INTERVAL) begin
               brk_in = 1'b0;
               il_in  = work_ms(ic_ff, cfg);
            end
            sound = SND_MODE;
         end
         CMD_HALT: begin
            run_in = 1'b0;
         end
         default: begin
            sound = SND_NONE;
         end
      endcase
   end

   // The result reflects the state after the command has been applied.
   always_comb begin
      preset   = 2'd0;
      in_break = 1'b0;
      case (mode_in)
         MODE_STOPWATCH: begin
            shown = acc_in + (run_in ? (now_ms - start_in) : 32'd0);
         end
         MODE_COUNTDOWN: begin
            shown  = cdl_in;
            preset = cdc_in;
         end
         default: begin
            shown    = il_in;
            preset   = {1'b0, ic_in};
            in_break = brk_in;
         end
      endcase
   end

   assign result.mode     = mode_in;
   assign result.running  = run_in;
   assign result.in_break = in_break;
   assign result.preset   = preset;
   assign result.shown    = shown;
   assign result.sound    = sound;
   assign result.stop     = stop;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_STOPWATCH;
         run_ff   <= 1'b0;
         acc_ff   <= 32'd0;
         start_ff <= 32'd0;
         cdl_ff   <= 32'd0;
         last_ff  <= NO_SECOND;
         cdc_ff   <= 2'd0;
         ic_ff    <= 1'b0;
         brk_ff   <= 1'b0;
         il_ff    <= 32'd0;
      end else if (item_fire) begin
         mode_ff  <= mode_in;
         run_ff   <= run_in;
         acc_ff   <= acc_in;
         start_ff <= start_in;
         cdl_ff   <= cdl_in;
         last_ff  <= last_in;
         cdc_ff   <= cdc_in;
         ic_ff    <= ic_in;
         brk_ff   <= brk_in;
         il_ff    <= il_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_mode_change_stops: assert property (@(posedge clock) disable iff (reset)
      item_fire && cmd == CMD_MODE |=> !run_ff)
      else $error("timer still running after a mode change");

   a_state_holds_when_idle: assert property (@(posedge clock) disable iff (reset)
      !item_fire |=> $stable(cdl_ff) && $stable(il_ff) && $stable(acc_ff)
                     && $stable(mode_ff) && $stable(run_ff))
      else $error("timer state changed without a request");

   a_done_is_zero: assert property (@(posedge clock) disable iff (reset)
      item_fire && result.sound == SND_DONE |-> !result.running && result.shown == 32'd0)
      else $error("countdown done without stopping at zero");

   a_stop_tone_cause: assert property (@(posedge clock) disable iff (reset)
      item_fire && result.stop |-> run_ff && cmd == CMD_LONG)
      else $error("stop tone without a long press on a running timer");

   a_choice_in_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cdc_ff} < 3'(COUNTDOWN_PRESETS))
      else $error("countdown preset choice out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/stopwatch_countdown_interval_timer_top.sv
// Top level of the three-mode millisecond timer: request and result registers.
//
//   Channel  Direction  Payload
//   req_     in         tuser[2:0] cmd; tdata[31:0] now_ms
//   rsp_     out        tdata: mode, running, in_break, preset_index, shown_ms,
//                       sound_event, stop_tone (low bit first)
//   csr_     in         APB-style, registers at byte address 4*i
//
// A request is applied to the timer state once it is in the input register and the
// result register is free or being emptied; the result register loads at the same edge
// that updates the timer state. Throughput is one request per clock while the result
// is not stalled. Reset is synchronous and active high; it clears the timer state and
// loads the register reset values. A stalled result holds the result register while
// one more request may wait in the input register.
`timescale 1ns / 1ps
`default_nettype none

module stopwatch_countdown_interval_timer_top
   import swcd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [31:0]           req_tdata,   // [31:0] now_ms
   input  wire logic [2:0]            req_tuser,   // [2:0] cmd
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [1:0] mode, [2] running, [3] in_break, [5:4] preset_index,
   // [37:6] shown_ms, [40:38] sound_event, [41] stop_tone, [47:42] zero
   output logic [47:0]                rsp_tdata,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   cfg_type     cfg;
   result_type  result;

   logic        in_valid_ff, in_valid_in;
   logic [2:0]  in_cmd_ff;
   logic [31:0] in_now_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff, rsp_data_in;
   logic        req_accept;
   logic        fire;

   swcd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   swcd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .item_fire (fire),
      .cmd       (in_cmd_ff),
      .now_ms    (in_now_ff),
      .cfg       (cfg),
      .result    (result)
   );

   // A request is applied when the result register is free or being emptied.
   assign fire        = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || fire;
   assign req_accept  = req_tvalid && req_tready;

   assign in_valid_in  = req_accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in  = fire ? result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cmd_ff <= req_tuser;
         in_now_ff <= req_tdata;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

endmodule

`default_nettype wire
